// ===== rtl/gf128_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf128_pkg
// Types, constants and bit-level helpers for the GF(2^128) field unit.
// Field polynomial x^128 + x^7 + x^2 + x + 1, bit i = coefficient of x^i.
// ----------------------------------------------------------------------------
package gf128_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_SQR = 2'd2,
        OP_INV = 2'd3
    } t_op;

    typedef struct packed {
        t_op         req_type;
        logic [63:0] a_low;
        logic [63:0] a_high;
        logic [63:0] b_low;
        logic [63:0] b_high;
    } t_req;

    typedef struct packed {
        logic [63:0] r_low;
        logic [63:0] r_high;
    } t_rsp;

    // Per-item context carried down the pipeline.
    typedef struct packed {
        t_op          op;
        logic [127:0] a;
        logic [127:0] cur;
    } t_ctx;

    // After operand prep: multiplicand pair.
    typedef struct packed {
        t_ctx         ctx;
        logic [127:0] u;
        logic [127:0] v;
    } t_sa;

    // After the three Karatsuba partial products.
    typedef struct packed {
        t_ctx         ctx;
        logic [127:0] ll;
        logic [127:0] hh;
        logic [127:0] mm;
    } t_sb;

    // Columns of a 128x128 GF(2) matrix: entry i is the image of x^i.
    typedef logic [127:0][127:0] t_mat;

    localparam int ROUNDS = 12;

    // Addition chain for a^(2^127-1): each round squares k times and
    // multiplies by either the running value or a itself.
    // 1 -> 2 -> 3 -> 6 -> 7 -> 14 -> 15 -> 30 -> 31 -> 62 -> 63 -> 126 -> 127
    localparam int ROUND_SQR [ROUNDS] = '{1, 1, 3, 1, 7, 1, 15, 1, 31, 1, 63, 1};
    localparam bit ROUND_USE_A [ROUNDS] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                                            1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    localparam int RED_SH7  = 7;
    localparam int RED_SH57 = 57;
    localparam int RED_SH62 = 62;
    localparam int RED_SH63 = 63;

    function automatic logic [127:0] clmul64(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] p;
        p = '0;
        for (int i = 0; i < 64; i++) begin
            if (y[i]) begin
                p = p ^ ({64'd0, x} << i);
            end
        end
        return p;
    endfunction

    // Two-fold reduction of a 256-bit product.
    function automatic logic [127:0] reduce256(input logic [255:0] w);
        logic [63:0] w0, w1, w2, w3;
        w0 = w[63:0];
        w1 = w[127:64];
        w2 = w[191:128];
        w3 = w[255:192];
        w1 = w1 ^ (w3 << RED_SH7) ^ (w3 << 2) ^ (w3 << 1) ^ w3;
        w2 = w2 ^ (w3 >> RED_SH57) ^ (w3 >> RED_SH62) ^ (w3 >> RED_SH63);
        w0 = w0 ^ (w2 << RED_SH7) ^ (w2 << 2) ^ (w2 << 1) ^ w2;
        w1 = w1 ^ (w2 >> RED_SH57) ^ (w2 >> RED_SH62) ^ (w2 >> RED_SH63);
        return {w1, w0};
    endfunction

    // Squaring: spread bits, then reduce. Only used at elaboration.
    function automatic logic [127:0] sqr128(input logic [127:0] x);
        logic [255:0] w;
        w = '0;
        for (int i = 0; i < 128; i++) begin
            w[2*i] = x[i];
        end
        return reduce256(w);
    endfunction

    // Matrix of the linear map x -> x^(2^k).
    function automatic t_mat sqr_pow_mat(input int k);
        t_mat         m;
        logic [127:0] e;
        for (int i = 0; i < 128; i++) begin
            e = 128'd1 << i;
            for (int j = 0; j < k; j++) begin
                e = sqr128(e);
            end
            m[i] = e;
        end
        return m;
    endfunction

    function automatic logic [127:0] mat_apply(input t_mat m, input logic [127:0] x);
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < 128; i++) begin
            if (x[i]) begin
                r = r ^ m[i];
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/gf2_128_field_unit_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_128_field_unit_top
// GF(2^128) add / multiply / square / invert, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one request per cycle while not stalled and returns one response per
// request, in order. The pipe is twelve multiply rounds of three
// stages each (operand prep with a constant power-of-two map, three 64x64
// carry-less products, combine and reduce) plus one output stage. Multiply,
// square and add finish in the first round and ride through the rest;
// invert walks the Itoh-Tsujii chain over all twelve rounds and the output
// stage squares the result, so zero inverts to zero. A stall on the response
// side freezes the whole pipe and is echoed to the request side.
module gf2_128_field_unit_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_stall,
    input  gf128_pkg::t_req   i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_stall,
    output gf128_pkg::t_rsp   o_rsp
);

    localparam int R = gf128_pkg::ROUNDS;

    logic en;
    assign en          = !(o_rsp_valid && i_rsp_stall);
    assign o_req_stall = !en;

    logic [R-1:0]    r_va, r_vb, r_vc;
    gf128_pkg::t_sa  r_sa [R];
    gf128_pkg::t_sb  r_sb [R];
    gf128_pkg::t_ctx r_ct [R];

    gf128_pkg::t_ctx in_ctx;
    assign in_ctx.op  = i_req.req_type;
    assign in_ctx.a   = {i_req.a_high, i_req.a_low};
    assign in_ctx.cur = {i_req.a_high ^ i_req.b_high, i_req.a_low ^ i_req.b_low};

    // valid bits: round g stage c feeds round g+1 stage a
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= '0;
            r_vb <= '0;
            r_vc <= '0;
        end else if (en) begin
            r_va <= {r_vc[R-2:0], i_req_valid};
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    for (genvar g = 0; g < R; g++) begin : g_round
        localparam gf128_pkg::t_mat M = gf128_pkg::sqr_pow_mat(gf128_pkg::ROUND_SQR[g]);

        gf128_pkg::t_ctx ctx_in;
        gf128_pkg::t_sa  n_sa;
        gf128_pkg::t_sb  n_sb;
        gf128_pkg::t_ctx n_ct;
        logic            active;
        logic [127:0]    mid;
        logic [255:0]    w;

        if (g == 0) begin : g_first
            assign ctx_in = in_ctx;
        end else begin : g_next
            assign ctx_in = r_ct[g-1];
        end

        // operand prep
        always_comb begin
            n_sa.ctx = ctx_in;
            if (g == 0) begin
                n_sa.u = (ctx_in.op == gf128_pkg::OP_INV)
                       ? gf128_pkg::mat_apply(M, ctx_in.a) : ctx_in.a;
                n_sa.v = (ctx_in.op == gf128_pkg::OP_MUL)
                       ? {i_req.b_high, i_req.b_low} : ctx_in.a;
            end else begin
                n_sa.u = gf128_pkg::mat_apply(M, ctx_in.cur);
                n_sa.v = gf128_pkg::ROUND_USE_A[g] ? ctx_in.a : ctx_in.cur;
            end
        end

        // Karatsuba partial products
        always_comb begin
            n_sb.ctx = r_sa[g].ctx;
            n_sb.ll  = gf128_pkg::clmul64(r_sa[g].u[63:0], r_sa[g].v[63:0]);
            n_sb.hh  = gf128_pkg::clmul64(r_sa[g].u[127:64], r_sa[g].v[127:64]);
            n_sb.mm  = gf128_pkg::clmul64(r_sa[g].u[63:0] ^ r_sa[g].u[127:64],
                                          r_sa[g].v[63:0] ^ r_sa[g].v[127:64]);
        end

        // combine and reduce
        always_comb begin
            active = (g == 0) ? (r_sb[g].ctx.op != gf128_pkg::OP_ADD)
                              : (r_sb[g].ctx.op == gf128_pkg::OP_INV);
            mid    = r_sb[g].mm ^ r_sb[g].ll ^ r_sb[g].hh;
            w      = {r_sb[g].hh, 128'd0} ^ {64'd0, mid, 64'd0} ^ {128'd0, r_sb[g].ll};
            n_ct   = r_sb[g].ctx;
            if (active) begin
                n_ct.cur = gf128_pkg::reduce256(w);
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sa[g] <= n_sa;
                r_sb[g] <= n_sb;
                r_ct[g] <= n_ct;
            end
        end
    end

    // output stage: final squaring closes the inverse chain
    localparam gf128_pkg::t_mat MSQ = gf128_pkg::sqr_pow_mat(1);

    logic            r_ov;
    gf128_pkg::t_rsp r_out;
    logic [127:0]    n_res;

    always_comb begin
        n_res = (r_ct[R-1].op == gf128_pkg::OP_INV)
              ? gf128_pkg::mat_apply(MSQ, r_ct[R-1].cur) : r_ct[R-1].cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_vc[R-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.r_low  <= n_res[63:0];
            r_out.r_high <= n_res[127:64];
        end
    end

    assign o_rsp_valid = r_ov;
    assign o_rsp       = r_out;

`ifndef SYNTHESIS
    // a frozen pipe keeps every valid bit
    a_hold_valids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_stall |=> ($stable(r_va) && $stable(r_vb) && $stable(r_vc) && $stable(r_ov)))
        else $error("pipeline valids moved during stall");

    // an accepted request enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |=> r_va[0])
        else $error("accepted request lost at entry");

    // non-invert results pass the last round unchanged
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vb[R-1] && r_sb[R-1].ctx.op != gf128_pkg::OP_INV)
        |=> (r_ct[R-1].cur == $past(r_sb[R-1].ctx.cur)))
        else $error("pass-through result altered");
`endif

endmodule
